@@ hdl/tridiagonal_solver_core_assert.svh @@
// assertion macros for the tridiagonal solver
`ifndef TRIDIAGONAL_SOLVER_CORE_ASSERT_SVH
`define TRIDIAGONAL_SOLVER_CORE_ASSERT_SVH
// implication checked every clock outside reset
`define TS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tridiagonal solver check failed");
// next-cycle implication
`define TS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tridiagonal solver check failed");
`endif

@@ hdl/tds_pkg.sv @@
// shared types and constants of the tridiagonal solver
package tds_pkg;
  localparam int MAX_ROWS_DEF = 64;
  localparam int FW = 32;
  localparam int IW = 6;

  typedef struct packed {
    logic signed [31:0] sub_diag;
    logic signed [31:0] main_diag;
    logic signed [31:0] super_diag;
    logic signed [31:0] rhs;
    logic               last_row;
  } req_t;

  typedef struct packed {
    logic signed [31:0] solution;
    logic [5:0]         row_index;
    logic               last;
    logic               singular;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch request and fetch previous row
    logic den_calc;  // form numerators and denominator
    logic div_start; // start both quotient units
    logic store;     // write p and q
    logic bs_load;   // seed back substitution
    logic bs_read;   // read p,q of row k-1
    logic bs_mul;    // p*x product
    logic bs_sum;    // finish x
    logic out_load;  // load output register
    logic clear;     // end of system
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic is_last;
    logic k_zero;
  } sts_t;
endpackage

@@ hdl/tds_div.sv @@
// serial restoring divider, Q16.16 quotient, truncated and saturated
module tds_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic               done,
  output logic signed [31:0] quo,
  output logic               flag
);
  // quotient bits from 63+16 down, two bits per cycle while busy
  logic [79:0]  n_sh;
  logic [64:0]  rem;
  logic [40:0]  q;
  logic [63:0]  d;
  logic         neg;
  logic         big;
  logic         busy;
  logic [6:0]   cnt;
  logic [64:0]  r1, r2;
  logic [40:0]  q1, q2;
  logic [31:0]  lim;

  always_comb begin
    r1 = {rem[63:0], n_sh[79]};
    q1 = {q[39:0], 1'b0};
    if (r1 >= {1'b0, d}) begin
      r1 = r1 - {1'b0, d};
      q1[0] = 1'b1;
    end
    r2 = {r1[63:0], n_sh[78]};
    q2 = {q1[39:0], 1'b0};
    if (r2 >= {1'b0, d}) begin
      r2 = r2 - {1'b0, d};
      q2[0] = 1'b1;
    end
    lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg  <= num[63] ^ den[63];
        n_sh <= {(num[63] ? 64'(-num) : 64'(num)), 16'd0};
        d    <= den[63] ? 64'(-den) : 64'(den);
        rem  <= '0;
        q    <= '0;
        big  <= 1'b0;
        cnt  <= 7'd40;
        busy <= (den != 64'sd0);
        if (den == 64'sd0) begin
          done <= 1'b1;
          quo  <= '0;
          flag <= 1'b1;
        end
      end else if (busy) begin
        rem  <= r2;
        q    <= q2;
        n_sh <= {n_sh[77:0], 2'b00};
        if (q1[40] || q2[40]) big <= 1'b1;
        cnt  <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (big || q1[40] || q2[40] || q2 > {9'd0, lim}) begin
            flag <= 1'b1;
            quo  <= neg ? 32'(-{1'b0, lim}) : lim;
          end else begin
            flag <= 1'b0;
            quo  <= neg ? 32'(-q2[31:0]) : q2[31:0];
          end
        end
      end
    end
  end
endmodule

@@ hdl/tds_datapath.sv @@
// datapath of the tridiagonal solver: sweep memories, dividers, back substitution
module tds_datapath #(
  parameter int MAX_ROWS = tds_pkg::MAX_ROWS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  tds_pkg::req_t  req,
  input  tds_pkg::cmd_t  cmd,
  output tds_pkg::sts_t  sts,
  output tds_pkg::rsp_t  rsp_d
);
  localparam int AW = $clog2(MAX_ROWS);
  logic signed [31:0] p_mem [MAX_ROWS];
  logic signed [31:0] q_mem [MAX_ROWS];
  logic [AW:0]        rows_in;
  logic               singular_seen;
  logic [AW-1:0]      idx;
  logic [AW-1:0]      k;
  logic signed [31:0] a, b, c, d, pp, qq, rp, rq, x;
  logic               first, is_last;
  logic signed [63:0] ap, aq, den, nump, numq, prod;
  logic               dp_done, dq_done, fp, fq, dp_seen, dq_seen;
  logic signed [31:0] quo_p, quo_q, qp_r, qq_r;
  logic signed [63:0] s;
  logic signed [47:0] fl;

  assign sts.div_done = dp_seen && dq_seen;
  assign sts.is_last  = is_last;
  assign sts.k_zero   = (k == '0);

  tds_div u_div_p (.clk, .rst, .start(cmd.div_start), .num(nump), .den(den),
                   .done(dp_done), .quo(quo_p), .flag(fp));
  tds_div u_div_q (.clk, .rst, .start(cmd.div_start), .num(numq), .den(den),
                   .done(dq_done), .quo(quo_q), .flag(fq));

  always_comb begin
    s  = prod + ($signed({{16{rq[31]}}, rq}) <<< 16);
    fl = s[63:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in       <= '0;
      singular_seen <= 1'b0;
      dp_seen       <= 1'b0;
      dq_seen       <= 1'b0;
    end else begin
      if (cmd.div_start) begin
        dp_seen <= 1'b0;
        dq_seen <= 1'b0;
      end else begin
        if (dp_done) begin dp_seen <= 1'b1; qp_r <= quo_p; if (fp) singular_seen <= 1'b1; end
        if (dq_done) begin dq_seen <= 1'b1; qq_r <= quo_q; if (fq) singular_seen <= 1'b1; end
      end
      if (cmd.store) rows_in <= (AW+1)'(idx) + 1'b1;
      if (cmd.clear) begin
        rows_in       <= '0;
        singular_seen <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx     <= (rows_in >= (AW+1)'(MAX_ROWS)) ? AW'(MAX_ROWS-1) : rows_in[AW-1:0];
      first   <= (rows_in == '0);
      is_last <= req.last_row || (rows_in >= (AW+1)'(MAX_ROWS-1));
      a <= req.sub_diag; b <= req.main_diag; c <= req.super_diag; d <= req.rhs;
      pp <= p_mem[AW'(rows_in[AW-1:0] - 1'b1)];
      qq <= q_mem[AW'(rows_in[AW-1:0] - 1'b1)];
    end
    if (cmd.den_calc) begin
      ap   <= first ? 64'sd0 : a * pp;
      aq   <= first ? 64'sd0 : a * qq;
    end
    if (cmd.store) begin
      p_mem[idx] <= qp_r;
      q_mem[idx] <= qq_r;
    end
    if (cmd.bs_load) begin
      x <= qq_r;
      k <= idx;
    end
    if (cmd.bs_read) begin
      rp <= p_mem[AW'(k - 1'b1)];
      rq <= q_mem[AW'(k - 1'b1)];
      k  <= k - 1'b1;
    end
    if (cmd.bs_mul) prod <= rp * x;
    if (cmd.bs_sum) begin
      if (fl > 48'sh7FFF_FFFF) x <= 32'h7FFF_FFFF;
      else if (fl < -48'sh8000_0000) x <= 32'h8000_0000;
      else x <= fl[31:0];
    end
    if (cmd.out_load) begin
      rsp_d.solution  <= x;
      rsp_d.row_index <= 6'(k);
      rsp_d.last      <= (k == '0);
      rsp_d.singular  <= singular_seen;
    end
  end

  always_comb begin
    den  = ($signed({{16{b[31]}}, b}) <<< 16) + ap;
    nump = is_last ? 64'sd0 : -($signed({{16{c[31]}}, c}) <<< 16);
    numq = ($signed({{16{d[31]}}, d}) <<< 16) - aq;
  end
endmodule

@@ hdl/tds_ctrl.sv @@
// controller state machine of the tridiagonal solver
module tds_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_fire,
  input  logic          out_busy,
  input  tds_pkg::sts_t sts,
  output tds_pkg::cmd_t cmd,
  output logic          in_ready,
  output logic          out_set
);
  localparam logic [3:0] S_IDLE = 4'd0, S_DEN = 4'd1, S_START = 4'd2, S_DIV = 4'd3,
                         S_STORE = 4'd4, S_SEED = 4'd5, S_EMIT = 4'd6, S_READ = 4'd7,
                         S_MUL = 4'd8, S_SUM = 4'd9, S_CLR = 4'd10;
  logic [3:0] state, state_next;

  always_comb begin
    cmd = '0;
    out_set = 1'b0;
    in_ready = (state == S_IDLE);
    state_next = state;
    case (state)
      S_IDLE:  if (in_fire) begin cmd.load = 1'b1; state_next = S_DEN; end
      S_DEN:   begin cmd.den_calc = 1'b1; state_next = S_START; end
      S_START: begin cmd.div_start = 1'b1; state_next = S_DIV; end
      S_DIV:   if (sts.div_done) state_next = S_STORE;
      S_STORE: begin
        cmd.store = 1'b1;
        state_next = sts.is_last ? S_SEED : S_IDLE;
      end
      S_SEED:  begin cmd.bs_load = 1'b1; state_next = S_EMIT; end
      S_EMIT:  if (!out_busy) begin
        cmd.out_load = 1'b1;
        out_set = 1'b1;
        state_next = sts.k_zero ? S_CLR : S_READ;
      end
      S_READ:  begin cmd.bs_read = 1'b1; state_next = S_MUL; end
      S_MUL:   begin cmd.bs_mul = 1'b1; state_next = S_SUM; end
      S_SUM:   begin cmd.bs_sum = 1'b1; state_next = S_EMIT; end
      S_CLR:   begin cmd.clear = 1'b1; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end
endmodule

@@ hdl/tridiagonal_solver_core.sv @@
// Thomas-algorithm tridiagonal solver in signed Q16.16, top level.
// Rows enter one request at a time; the next row is accepted only once the last
// is stored, after the two serial dividers (two quotient bits per iteration)
// have formed P and Q in parallel; a zero denominator skips the iterations.
// Non-last rows return nothing; no clearing pass follows reset. On the last row
// (or the MAX_ROWS-th) the solution is sent from the highest index down to
// zero, one component per pass through the emit, read, multiply and sum states
// of the single back-substitution multiplier, held in emit while output stalls.
module tridiagonal_solver_core #(
  parameter int MAX_ROWS = tds_pkg::MAX_ROWS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  tds_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output tds_pkg::rsp_t out_data
);
  tds_pkg::cmd_t cmd;
  tds_pkg::sts_t sts;
  logic          in_ready, out_set, in_fire;

  // a request is taken only while the controller idles
  assign in_stall = !in_ready;
  assign in_fire  = in_valid && in_ready;

  tds_ctrl u_ctrl (.clk, .rst, .in_fire, .out_busy(out_valid && out_stall),
                   .sts, .cmd, .in_ready, .out_set);

  tds_datapath #(.MAX_ROWS(MAX_ROWS)) u_dp (.clk, .rst, .req(in_data), .cmd, .sts,
                                           .rsp_d(out_data));

  // output valid: set on load, cleared when the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_set) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end
endmodule

@@ hdl/tds_checker.sv @@
// port-level checks of the tridiagonal solver
`include "tridiagonal_solver_core_assert.svh"
module tds_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input tds_pkg::rsp_t out_data
);
  // a taken row holds off the next one
  `TS_ASSERT_NXT(a_in_busy, in_valid && !in_stall, in_stall)
  // held result stays put
  `TS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  // after a last result, the next result cannot follow at once
  `TS_ASSERT_NXT(a_last_gap, out_valid && !out_stall && out_data.last, !out_valid)
endmodule

bind tridiagonal_solver_core tds_checker u_chk (.clk, .rst, .in_valid, .in_stall,
  .out_valid, .out_stall, .out_data);
